[rtl/mfr_pkg.sv]
// shared definitions for the muskingum flow routing core
// default widths, register index codes and the stage control struct
// no dependencies
package mfr_pkg;

  localparam int FLOW_WIDTH_DEF = 32;
  localparam int COEF_WIDTH_DEF = 18;

  // configuration register index codes
  localparam int          REG_INDEX_W   = 1;
  localparam logic [0:0]  REG_COEF_NOW  = 1'b0;
  localparam logic [0:0]  REG_COEF_PREV = 1'b1;

  // control that travels with each request from one stage to the next
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

[rtl/mfr_feed.sv]
// front stages: input register with inflow sum, then the two feed-forward products
// c0*I + c1*I_prev plus the rounding half, registered for the recursion stage
// depends on mfr_pkg
module mfr_feed import mfr_pkg::*; #(
  parameter int FLOW_WIDTH = FLOW_WIDTH_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  localparam int ACC_W = FLOW_WIDTH + COEF_WIDTH + 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_first,
  input  logic                         in_last,
  input  logic signed [FLOW_WIDTH-1:0] up_a,
  input  logic signed [FLOW_WIDTH-1:0] up_b,
  input  logic signed [FLOW_WIDTH-1:0] in_loc,
  input  logic signed [COEF_WIDTH-1:0] coef_now,
  input  logic signed [COEF_WIDTH-1:0] coef_prev,
  output stage_ctl_t                   out_ctl,
  input  logic                         out_ready,
  output logic                         out_first,
  output logic signed [FLOW_WIDTH:0]   out_inflow,
  output logic signed [FLOW_WIDTH-1:0] out_loc,
  output logic signed [ACC_W-1:0]      out_acc
);

  localparam int PROD_W = FLOW_WIDTH + COEF_WIDTH + 1;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_WIDTH - 3);

  logic                         s0_valid;
  logic                         s0_first;
  logic                         s0_last;
  logic signed [FLOW_WIDTH:0]   s0_inflow;
  logic signed [FLOW_WIDTH-1:0] s0_loc;
  logic                         s0_ready;

  logic                         s1_valid;
  logic                         s1_first;
  logic                         s1_last;
  logic signed [FLOW_WIDTH:0]   s1_inflow;
  logic signed [FLOW_WIDTH-1:0] s1_loc;
  logic signed [ACC_W-1:0]      s1_acc;
  logic                         s1_ready;

  logic signed [FLOW_WIDTH:0]   prev_inflow;
  logic signed [PROD_W-1:0]     prod_now;
  logic signed [PROD_W-1:0]     prod_prev;
  logic signed [ACC_W-1:0]      acc_next;

  assign s1_ready = !s1_valid || out_ready;
  assign s0_ready = !s0_valid || s1_ready;
  assign in_ready = s0_ready;

  assign prod_now  = PROD_W'(coef_now) * PROD_W'(s0_inflow);
  assign prod_prev = PROD_W'(coef_prev) * PROD_W'(prev_inflow);
  assign acc_next  = ACC_W'(prod_now) + ACC_W'(prod_prev) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid    <= 1'b0;
      s1_valid    <= 1'b0;
      prev_inflow <= '0;
    end else begin
      if (s0_ready) begin
        s0_valid <= in_valid;
      end
      if (s1_ready) begin
        s1_valid <= s0_valid;
      end
      // history advances as each request leaves the product stage
      if (s0_valid && s1_ready) begin
        prev_inflow <= s0_inflow;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s0_ready) begin
      s0_first  <= in_first;
      s0_last   <= in_last;
      s0_inflow <= (FLOW_WIDTH + 1)'(up_a) + (FLOW_WIDTH + 1)'(up_b);
      s0_loc    <= in_loc;
    end
    if (s0_valid && s1_ready) begin
      s1_first  <= s0_first;
      s1_last   <= s0_last;
      s1_inflow <= s0_inflow;
      s1_loc    <= s0_loc;
      s1_acc    <= acc_next;
    end
  end

  assign out_ctl.valid = s1_valid;
  assign out_ctl.last  = s1_last;
  assign out_first     = s1_first;
  assign out_inflow    = s1_inflow;
  assign out_loc       = s1_loc;
  assign out_acc       = s1_acc;

endmodule

[rtl/mfr_recur.sv]
// recursion stage: adds c2*O_prev, rounds to Q16.16, clips to two guard bits
// and holds the routed outflow history
// depends on mfr_pkg
module mfr_recur import mfr_pkg::*; #(
  parameter int FLOW_WIDTH = FLOW_WIDTH_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  localparam int ACC_W = FLOW_WIDTH + COEF_WIDTH + 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  stage_ctl_t                   in_ctl,
  output logic                         in_ready,
  input  logic                         in_first,
  input  logic signed [FLOW_WIDTH:0]   in_inflow,
  input  logic signed [FLOW_WIDTH-1:0] in_loc,
  input  logic signed [ACC_W-1:0]      in_acc,
  input  logic signed [COEF_WIDTH-1:0] coef_now,
  input  logic signed [COEF_WIDTH-1:0] coef_prev,
  output stage_ctl_t                   out_ctl,
  input  logic                         out_ready,
  output logic signed [FLOW_WIDTH+1:0] out_routed,
  output logic signed [FLOW_WIDTH-1:0] out_loc
);

  localparam int C2_W    = COEF_WIDTH + 2;
  localparam int ROUTE_W = FLOW_WIDTH + 2;
  localparam int P2_W    = C2_W + ROUTE_W;
  localparam int Q_W     = ACC_W - (COEF_WIDTH - 2);
  localparam logic signed [C2_W-1:0] COEF_ONE = C2_W'(1) << (COEF_WIDTH - 2);

  logic                      valid;
  logic                      last;
  logic signed [ROUTE_W-1:0] routed;
  logic signed [FLOW_WIDTH-1:0] loc;
  logic signed [ROUTE_W-1:0] prev_routed;

  logic signed [C2_W-1:0]    coef_fb;
  logic signed [P2_W-1:0]    prod_fb;
  logic signed [ACC_W-1:0]   sum;
  logic signed [Q_W-1:0]     quot;
  logic                      in_range;
  logic signed [ROUTE_W-1:0] clipped;
  logic signed [ROUTE_W-1:0] routed_next;
  logic                      take;

  assign in_ready = !valid || out_ready;
  assign take     = in_ctl.valid && in_ready;

  // c2 = 1 - c0 - c1, exact at two extra bits
  assign coef_fb = COEF_ONE - C2_W'(coef_now) - C2_W'(coef_prev);
  assign prod_fb = P2_W'(coef_fb) * P2_W'(prev_routed);
  assign sum     = in_acc + ACC_W'(prod_fb);
  // arithmetic shift right by the coefficient fraction: floor
  assign quot    = sum[ACC_W-1:COEF_WIDTH-2];

  assign in_range = (&quot[Q_W-1:ROUTE_W-1]) || !(|quot[Q_W-1:ROUTE_W-1]);

  always_comb begin
    if (in_range) begin
      clipped = quot[ROUTE_W-1:0];
    end else if (quot[Q_W-1]) begin
      clipped = {1'b1, {(ROUTE_W - 1){1'b0}}};
    end else begin
      clipped = {1'b0, {(ROUTE_W - 1){1'b1}}};
    end
    // first step of a series passes the inflow straight through
    routed_next = in_first ? ROUTE_W'(in_inflow) : clipped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= 1'b0;
      prev_routed <= '0;
    end else begin
      if (in_ready) begin
        valid <= in_ctl.valid;
      end
      if (take) begin
        prev_routed <= routed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      last   <= in_ctl.last;
      routed <= routed_next;
      loc    <= in_loc;
    end
  end

  assign out_ctl.valid = valid;
  assign out_ctl.last  = last;
  assign out_routed    = routed;
  assign out_loc       = loc;

endmodule

[rtl/mfr_out.sv]
// output stage: adds local inflow, saturates to the flow width, holds the result
// register that faces the downstream receiver
// depends on mfr_pkg
module mfr_out import mfr_pkg::*; #(
  parameter int FLOW_WIDTH = FLOW_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  stage_ctl_t                   in_ctl,
  output logic                         in_ready,
  input  logic signed [FLOW_WIDTH+1:0] in_routed,
  input  logic signed [FLOW_WIDTH-1:0] in_loc,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [FLOW_WIDTH-1:0] routed_flow,
  output logic                         saturated,
  output logic                         last_out
);

  localparam int SUM_W = FLOW_WIDTH + 3;

  logic signed [SUM_W-1:0]      total;
  logic                         in_range;
  logic signed [FLOW_WIDTH-1:0] flow_next;

  assign in_ready = !out_valid || out_ready;
  assign total    = SUM_W'(in_routed) + SUM_W'(in_loc);
  assign in_range = (&total[SUM_W-1:FLOW_WIDTH-1]) || !(|total[SUM_W-1:FLOW_WIDTH-1]);

  always_comb begin
    if (in_range) begin
      flow_next = total[FLOW_WIDTH-1:0];
    end else if (total[SUM_W-1]) begin
      flow_next = {1'b1, {(FLOW_WIDTH - 1){1'b0}}};
    end else begin
      flow_next = {1'b0, {(FLOW_WIDTH - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ctl.valid && in_ready) begin
      routed_flow <= flow_next;
      saturated   <= !in_range;
      last_out    <= in_ctl.last;
    end
  end

endmodule

[rtl/muskingum_flow_routing_core.sv]
// muskingum flow routing core, top level
// holds the coefficient registers and chains mfr_feed, mfr_recur and mfr_out
// depends on mfr_pkg
//
// usage: one request on the slave stream is one time step of a river reach.
// s_tdata carries the two upstream branch flows and the local inflow, s_tuser
// marks the first step of a series and s_tlast its final step. each request
// gives exactly one result on the master stream: the routed flow in m_tdata,
// the clip flag in m_tuser and the echoed last mark in m_tlast.
// a result passes the input, product, recursion and output registers in order.
// throughput: one request per cycle while m_tready is high; the routing
// recursion closes through one multiply-add in the recursion stage, so a new
// step enters every clock. each stage has its own ready, so requests keep
// entering while a finished result waits; when the receiver stalls, the four
// stages fill and then s_tready drops. reset clears the flow history and sets
// c0 = 0 and c1 = 1.0. the user must write coefficients on the cfg port only
// while no request is in flight; the core itself does not enforce this.
module muskingum_flow_routing_core import mfr_pkg::*; #(
  parameter int FLOW_WIDTH = FLOW_WIDTH_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  localparam int S_TDATA_W = ((3 * FLOW_WIDTH + 7) / 8) * 8,
  localparam int M_TDATA_W = ((FLOW_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // upstream_a, upstream_b, local_inflow (lowest bits first)
  input  logic [S_TDATA_W-1:0]   s_tdata,
  // first_sample
  input  logic                   s_tuser,
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // routed_flow
  output logic [M_TDATA_W-1:0]   m_tdata,
  // saturated
  output logic                   m_tuser,
  output logic                   m_tlast,
  input  logic                   cfg_wr_en,
  input  logic [REG_INDEX_W-1:0] cfg_index,
  input  logic [COEF_WIDTH-1:0]  cfg_wdata
);

  localparam int ACC_W = FLOW_WIDTH + COEF_WIDTH + 6;
  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << (COEF_WIDTH - 2);

  logic signed [COEF_WIDTH-1:0] coef_now;
  logic signed [COEF_WIDTH-1:0] coef_prev;

  stage_ctl_t                   feed_ctl;
  logic                         feed_ready;
  logic                         feed_first;
  logic signed [FLOW_WIDTH:0]   feed_inflow;
  logic signed [FLOW_WIDTH-1:0] feed_loc;
  logic signed [ACC_W-1:0]      feed_acc;

  stage_ctl_t                   recur_ctl;
  logic                         recur_ready;
  logic signed [FLOW_WIDTH+1:0] recur_routed;
  logic signed [FLOW_WIDTH-1:0] recur_loc;

  logic signed [FLOW_WIDTH-1:0] routed_flow;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_now  <= '0;
      coef_prev <= COEF_ONE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_COEF_NOW:  coef_now  <= cfg_wdata;
        REG_COEF_PREV: coef_prev <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mfr_feed #(
    .FLOW_WIDTH (FLOW_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_feed (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_first   (s_tuser),
    .in_last    (s_tlast),
    .up_a       (s_tdata[FLOW_WIDTH-1:0]),
    .up_b       (s_tdata[2*FLOW_WIDTH-1:FLOW_WIDTH]),
    .in_loc     (s_tdata[3*FLOW_WIDTH-1:2*FLOW_WIDTH]),
    .coef_now   (coef_now),
    .coef_prev  (coef_prev),
    .out_ctl    (feed_ctl),
    .out_ready  (feed_ready),
    .out_first  (feed_first),
    .out_inflow (feed_inflow),
    .out_loc    (feed_loc),
    .out_acc    (feed_acc)
  );

  mfr_recur #(
    .FLOW_WIDTH (FLOW_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_recur (
    .clk        (clk),
    .rst        (rst),
    .in_ctl     (feed_ctl),
    .in_ready   (feed_ready),
    .in_first   (feed_first),
    .in_inflow  (feed_inflow),
    .in_loc     (feed_loc),
    .in_acc     (feed_acc),
    .coef_now   (coef_now),
    .coef_prev  (coef_prev),
    .out_ctl    (recur_ctl),
    .out_ready  (recur_ready),
    .out_routed (recur_routed),
    .out_loc    (recur_loc)
  );

  mfr_out #(
    .FLOW_WIDTH (FLOW_WIDTH)
  ) u_out (
    .clk         (clk),
    .rst         (rst),
    .in_ctl      (recur_ctl),
    .in_ready    (recur_ready),
    .in_routed   (recur_routed),
    .in_loc      (recur_loc),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .routed_flow (routed_flow),
    .saturated   (m_tuser),
    .last_out    (m_tlast)
  );

  assign m_tdata = M_TDATA_W'($unsigned(routed_flow));

endmodule
